@@ sv/nearest_vertex_snap_top_macros.svh @@
// Assertion macros for the nearest vertex snap block.
`ifndef NEAREST_VERTEX_SNAP_TOP_MACROS_SVH
`define NEAREST_VERTEX_SNAP_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NVS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define NVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define NVS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NVS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/nvs_pkg.sv @@
// Shared constants for the nearest vertex snap block.
package nvs_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam logic [1:0] CMD_ROW    = 2'd0;
	localparam logic [1:0] CMD_VERTEX = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;
	localparam logic [1:0] REG_TX = 2'd0;
	localparam logic [1:0] REG_TY = 2'd1;
	localparam logic [1:0] REG_TZ = 2'd2;
endpackage

@@ sv/nearest_vertex_snap_top.sv @@
// Nearest vertex search under an affine transform, with square root on finish.
// Usage: write target_x/y/z on the cfg port (cfg_we, cfg_index, cfg_data) while idle.
// Requests arrive on s_axis_*: command 0 loads a transform row, command 1 offers
// a vertex, command 2 finishes the search and emits one result on m_axis_*.
// Row commands and skipped or unknown commands pass through the wait state only.
// For a kept vertex, one shared 33x33 signed multiplier is used
// for nine transform products and three squares, one product per cycle,
// followed by saturation and a compare against the held candidate.
// On a finish, a restoring square root unit resolves one result bit per cycle
// until all 32 root bits are found, then the result is loaded into the output
// register and the held candidate is cleared.
// The block takes one request at a time; s_axis_tready is low while it works.
// A result waits in the output register while m_axis_tready is low; a later
// finish holds in its last step, with s_axis_tready low, until it is taken.
// Reset: identity transform, zero target, empty search, no result pending.
module nearest_vertex_snap_top
	import nvs_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command[1:0], row_index[3:2], val_a[35:4], val_b[67:36], val_c[99:68],
	// val_d[131:100], node_id[163:132], vertex_index[195:164], zero pad
	input  logic [199:0] s_axis_tdata,
	// skip
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// best_node[31:0], best_vertex[63:32], snap_x[95:64], snap_y[127:96],
	// snap_z[159:128], snap_distance[191:160]
	output logic [191:0] m_axis_tdata,
	// found
	output logic         m_axis_tuser,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	`include "nearest_vertex_snap_top_macros.svh"

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_SQ    = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_SQRT  = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;
	localparam logic [2:0] ST_WAIT  = 3'd6;

	logic [2:0]  state_q;
	logic signed [31:0] tgt_q [3];
	logic signed [31:0] m_q [12];
	logic signed [31:0] x_q, y_q, z_q;
	logic [31:0] node_q, vert_q;
	logic [1:0]  row_q;
	logic [1:0]  col_q;
	logic signed [67:0] acc_q;
	logic signed [31:0] w_q [3];
	logic [64:0] sq_q;
	logic hv_q;
	logic [31:0] hn_q, hvx_q;
	logic signed [31:0] hp_q [3];
	logic [63:0] hsq_q;
	logic [63:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic [191:0] out_q;
	logic out_found_q, out_valid_q;

	logic [1:0]  in_cmd, in_row;
	logic signed [31:0] in_a, in_b, in_c, in_d;
	assign in_cmd = s_axis_tdata[1:0];
	assign in_row = s_axis_tdata[3:2];
	assign in_a = s_axis_tdata[35:4];
	assign in_b = s_axis_tdata[67:36];
	assign in_c = s_axis_tdata[99:68];
	assign in_d = s_axis_tdata[131:100];

	// shared multiplier operands
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic signed [32:0] diff;
	always_comb begin
		diff = 33'(w_q[row_q]) - 33'(tgt_q[row_q]);
		if (state_q == ST_SQ) begin
			mul_a = diff;
			mul_b = diff;
		end else begin
			mul_a = 33'(m_q[4'(row_q) * 4'd4 + 4'(col_q)]);
			case (col_q)
				2'd0: mul_b = 33'(x_q);
				2'd1: mul_b = 33'(y_q);
				default: mul_b = 33'(z_q);
			endcase
		end
		prod = mul_a * mul_b;
	end

	// row finish: floor shift, add translation, saturate
	logic signed [67:0] shifted;
	logic signed [68:0] wsum;
	logic signed [31:0] wsat;
	assign shifted = (acc_q + 68'(prod)) >>> FRAC_BITS;
	always_comb begin
		wsum = 69'(shifted) + 69'(m_q[4'(row_q) * 4'd4 + 4'd3]);
		if (wsum > 69'sd2147483647) wsat = 32'h7FFFFFFF;
		else if (wsum < -69'sd2147483648) wsat = 32'h80000000;
		else wsat = wsum[31:0];
	end

	logic [64:0] sq_next;
	assign sq_next = sq_q + {1'b0, prod[63:0]};

	// square root step
	logic [65:0] sr_rem;
	logic [65:0] sr_try;
	always_comb begin
		sr_rem = {rem_q[63:0], hsq_q[63:62]} ;
		sr_try = {32'd0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 12; i++)
				m_q[i] <= ((i == 0) || (i == 5) || (i == 10)) ?
					32'(64'sd1 <<< FRAC_BITS) : 32'sd0;
			for (int i = 0; i < 3; i++) begin
				tgt_q[i] <= '0;
				hp_q[i] <= '0;
			end
			hv_q <= 1'b0;
			hn_q <= '0;
			hvx_q <= '0;
			hsq_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TX: tgt_q[0] <= cfg_data;
					REG_TY: tgt_q[1] <= cfg_data;
					REG_TZ: tgt_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						case (in_cmd)
							CMD_ROW: begin
								if (in_row != 2'd3) begin
									m_q[4'(in_row) * 4'd4]        <= in_a;
									m_q[4'(in_row) * 4'd4 + 4'd1] <= in_b;
									m_q[4'(in_row) * 4'd4 + 4'd2] <= in_c;
									m_q[4'(in_row) * 4'd4 + 4'd3] <= in_d;
								end
								state_q <= ST_WAIT;
							end
							CMD_VERTEX: begin
								x_q <= in_a;
								y_q <= in_b;
								z_q <= in_c;
								node_q <= s_axis_tdata[163:132];
								vert_q <= s_axis_tdata[195:164];
								row_q <= '0;
								col_q <= '0;
								acc_q <= '0;
								sq_q <= '0;
								state_q <= s_axis_tuser ? ST_WAIT : ST_MUL;
							end
							CMD_FINISH: begin
								rem_q <= '0;
								root_q <= '0;
								cnt_q <= '0;
								state_q <= ST_SQRT;
							end
							default: state_q <= ST_WAIT;
						endcase
					end
				end
				ST_MUL: begin
					if (col_q == 2'd2) begin
						w_q[row_q] <= wsat;
						acc_q <= '0;
						col_q <= '0;
						if (row_q == 2'd2) begin
							row_q <= '0;
							state_q <= ST_SQ;
						end else
							row_q <= row_q + 2'd1;
					end else begin
						acc_q <= acc_q + 68'(prod);
						col_q <= col_q + 2'd1;
					end
				end
				ST_SQ: begin
					if (sq_q[64] ||
							(diff[32] ? (diff < -33'sh0FFFFFFFF) : (diff > 33'sh0FFFFFFFF)))
						sq_q <= {1'b1, 64'd0};
					else
						sq_q <= sq_next;
					if (row_q == 2'd2)
						state_q <= ST_CMP;
					else
						row_q <= row_q + 2'd1;
				end
				ST_CMP: begin
					if (!hv_q || (!sq_q[64] && sq_q[63:0] < hsq_q) ||
							(sq_q[64] && hsq_q != 64'hFFFFFFFFFFFFFFFF && 1'b0)) begin
						hv_q <= 1'b1;
						hn_q <= node_q;
						hvx_q <= vert_q;
						for (int i = 0; i < 3; i++)
							hp_q[i] <= w_q[i];
						hsq_q <= sq_q[64] ? 64'hFFFFFFFFFFFFFFFF : sq_q[63:0];
					end
					state_q <= ST_WAIT;
				end
				ST_SQRT: begin
					if (sr_rem >= sr_try) begin
						rem_q <= 64'(sr_rem - sr_try);
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q <= sr_rem[63:0];
						root_q <= {root_q[30:0], 1'b0};
					end
					hsq_q <= {hsq_q[61:0], 2'b00};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_found_q <= hv_q;
						out_q <= hv_q ? {root_q, hp_q[2], hp_q[1], hp_q[0], hvx_q, hn_q}
							: '0;
						hv_q <= 1'b0;
						hn_q <= '0;
						hvx_q <= '0;
						for (int i = 0; i < 3; i++)
							hp_q[i] <= '0;
						hsq_q <= '0;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q;
	assign m_axis_tuser = out_found_q;

	`NVS_ASSERT_IMPL(a_ready_idle, clk, arst_n, s_axis_tready, state_q == ST_IDLE)
	`NVS_ASSERT_NEXT(a_emit_clear, clk, arst_n,
		state_q == ST_EMIT && !out_valid_q, m_axis_tvalid && !hv_q)
	`NVS_ASSERT_IMPL(a_sqrt_count, clk, arst_n, state_q == ST_SQRT, cnt_q < 6'd32)
endmodule

@@ bench/tb_top.sv @@
// Testbench for the nearest vertex snap block: directed and random requests against a predictor.
module tb_top;
	import nvs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] ROW_UNUSED = 2'd3;
	localparam int IDLE_CYCLES = 40;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct packed {
		logic        found;
		logic [31:0] node;
		logic [31:0] vtx;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] distance;
	} snap_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [199:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [191:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	nearest_vertex_snap_top dut (.*);

	always #1 clk = ~clk;

	longint xform[12];
	logic signed [31:0] tgt[3];
	bit held_ok;
	logic [31:0] held_node, held_vtx;
	logic [31:0] held_pos[3];
	bit [63:0] held_sq;
	snap_t snap_queue[$];
	int fails = 0;
	int hold_cycles = 0;

	function automatic longint map_row(int r, longint a, longint b, longint c);
		longint p[3];
		longint qsum;
		bit [63:0] rsum;
		longint s;
		p[0] = xform[r*4] * a;
		p[1] = xform[r*4+1] * b;
		p[2] = xform[r*4+2] * c;
		qsum = 0;
		rsum = 0;
		for (int i = 0; i < 3; i++) begin
			qsum += p[i] >>> FRAC;
			rsum += p[i] & ((64'd1 << FRAC) - 1);
		end
		s = qsum + longint'(rsum >> FRAC) + xform[r*4+3];
		if (s > S32_MAX) return S32_MAX;
		if (s < S32_MIN) return S32_MIN;
		return s;
	endfunction

	function automatic bit [63:0] square_of(longint w, longint t);
		longint d;
		bit [63:0] m;
		d = w - t;
		m = (d < 0) ? -d : d;
		if (m >= 64'h1_0000_0000) return '1;
		return m * m;
	endfunction

	function automatic bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
		bit [64:0] s;
		s = a + b;
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] n);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	task automatic predict_snap(logic [1:0] cmd, logic [1:0] row, logic signed [31:0] v[4],
			logic [31:0] node, logic [31:0] vtx, logic skip);
		longint w[3];
		bit [63:0] sq;
		snap_t r;
		if (cmd == CMD_ROW) begin
			if (row != ROW_UNUSED)
				for (int i = 0; i < 4; i++) xform[row*4+i] = v[i];
		end else if (cmd == CMD_VERTEX && !skip) begin
			sq = 0;
			for (int k = 0; k < 3; k++) begin
				w[k] = map_row(k, v[0], v[1], v[2]);
				sq = add_sat(sq, square_of(w[k], tgt[k]));
			end
			if (!held_ok || sq < held_sq) begin
				held_ok = 1;
				held_node = node;
				held_vtx = vtx;
				for (int k = 0; k < 3; k++) held_pos[k] = w[k][31:0];
				held_sq = sq;
			end
		end else if (cmd == CMD_FINISH) begin
			r = '0;
			if (held_ok) begin
				r.found = 1'b1;
				r.node = held_node;
				r.vtx = held_vtx;
				r.x = held_pos[0];
				r.y = held_pos[1];
				r.z = held_pos[2];
				r.distance = 32'(int_sqrt(held_sq));
			end
			snap_queue.push_back(r);
			held_ok = 0;
			held_node = 0;
			held_vtx = 0;
			held_pos = '{0, 0, 0};
			held_sq = 0;
		end
	endtask

	task automatic send_request(logic [1:0] cmd, logic [1:0] row, logic signed [31:0] v[4],
			logic [31:0] node, logic [31:0] vtx, logic skip);
		s_axis_tdata <= {4'd0, vtx, node, v[3], v[2], v[1], v[0], row, cmd};
		s_axis_tuser <= skip;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predict_snap(cmd, row, v, node, vtx, skip);
	endtask

	task automatic pause_sender();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3, 4: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_coeff(bit diag);
		case ($urandom_range(0, 5))
			0: return pick_value();
			1: return diag ? 32'sh00010000 : 0;
			default: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
		endcase
	endfunction

	task automatic send_row(logic [1:0] row, logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c, logic signed [31:0] d);
		logic signed [31:0] v[4];
		v = '{a, b, c, d};
		send_request(CMD_ROW, row, v, $urandom, $urandom, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic [31:0] node, logic [31:0] vtx, logic skip);
		logic signed [31:0] v[4];
		v = '{x, y, z, $urandom};
		send_request(CMD_VERTEX, 2'($urandom), v, node, vtx, skip);
	endtask

	task automatic send_finish();
		logic signed [31:0] v[4];
		v = '{$urandom, $urandom, $urandom, $urandom};
		send_request(CMD_FINISH, 2'($urandom), v, $urandom, $urandom,
			1'($urandom_range(0, 1)));
	endtask

	task automatic write_target(logic [1:0] idx, logic signed [31:0] val);
		s_axis_tvalid <= 1'b0;
		while (snap_queue.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		tgt[idx] = val;
	endtask

	task automatic set_target(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		write_target(REG_TX, x);
		write_target(REG_TY, y);
		write_target(REG_TZ, z);
	endtask

	task automatic test_directed();
		logic signed [31:0] v[4];
		send_finish();
		send_vertex(32'sh00010000, 32'sh00020000, 32'sh00030000, 32'd7, 32'd1, 1'b0);
		send_vertex(32'sh00010000, 32'sh00020000, 32'sh00030000, 32'd8, 32'd2, 1'b0);
		send_vertex(0, 0, 0, 32'hffffffff, 32'hffffffff, 1'b1);
		send_finish();
		send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'hffffffff, 0, 1'b0);
		send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 32'hffffffff, 1'b0);
		send_finish();
		send_row(2'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_row(2'd1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_row(2'd2, 32'shffff8000, 32'sh00000001, 32'shffffffff, 0);
		send_row(ROW_UNUSED, 0, 0, 0, 0);
		send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'd3, 32'd3, 1'b0);
		send_vertex(32'sh80000000, 32'shffffffff, 32'sh00000001, 32'd4, 32'd4, 1'b0);
		v = '{$urandom, $urandom, $urandom, $urandom};
		send_request(CMD_UNUSED, 2'd0, v, $urandom, $urandom, 1'b0);
		send_finish();
		send_row(2'd0, 32'sh00010000, 0, 0, 0);
		send_row(2'd1, 0, 32'sh00010000, 0, 0);
		send_row(2'd2, 0, 0, 32'sh00010000, 0);
		send_vertex(32'sh00050000, 0, 0, 32'd10, 32'd10, 1'b1);
		send_finish();
	endtask

	task automatic run_search(int nverts);
		if ($urandom_range(0, 2) != 0)
			for (int r = 0; r < 3; r++) begin
				send_row(2'(r), pick_coeff(r == 0), pick_coeff(r == 1), pick_coeff(r == 2),
					pick_value());
				pause_sender();
			end
		for (int i = 0; i < nverts; i++) begin
			send_vertex(pick_value(), pick_value(), pick_value(), $urandom, $urandom,
				$urandom_range(0, 5) == 0);
			pause_sender();
		end
		send_finish();
		pause_sender();
	endtask

	task automatic test_random(int n_items);
		int sent;
		int nv;
		logic signed [31:0] v[4];
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				v = '{$urandom, $urandom, $urandom, $urandom};
				send_request(2'($urandom), 2'($urandom), v, $urandom, $urandom,
					1'($urandom_range(0, 1)));
				sent++;
				pause_sender();
			end else begin
				nv = $urandom_range(0, 8);
				run_search(nv);
				sent += nv + 4;
			end
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 400;
		for (int i = 0; i < 4; i++) run_search(3);
	endtask

	initial begin
		for (int i = 0; i < 12; i++) xform[i] = (i % 5 == 0) ? (64'sd1 <<< FRAC) : 0;
		tgt = '{0, 0, 0};
		held_ok = 0;
		held_node = 0;
		held_vtx = 0;
		held_pos = '{0, 0, 0};
		held_sq = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250);
		set_target(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		test_directed();
		test_random(250);
		set_target(32'sh80000000, 32'sh80000000, 32'sh80000000);
		test_random(200);
		set_target($urandom, $urandom, $urandom);
		test_backpressure();
		test_random(150);
		set_target(32'sh00030000, 32'shfffd0000, 32'sh00001234);
		test_random(200);
		s_axis_tvalid <= 1'b0;
		while (snap_queue.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else if ((($time / 200) % 3) == 0) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= $urandom_range(0, 2) != 0;
		end
	end

	always @(posedge clk) begin
		snap_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (snap_queue.size() == 0) begin
				$error("result with no request pending");
				fails++;
			end else begin
				want = snap_queue.pop_front();
				if (m_axis_tuser !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, m_axis_tuser);
					fails++;
				end
				if (m_axis_tdata[31:0] !== want.node) begin
					$error("best_node: expected %h, got %h", want.node, m_axis_tdata[31:0]);
					fails++;
				end
				if (m_axis_tdata[63:32] !== want.vtx) begin
					$error("best_vertex: expected %h, got %h", want.vtx, m_axis_tdata[63:32]);
					fails++;
				end
				if (m_axis_tdata[95:64] !== want.x) begin
					$error("snap_x: expected %h, got %h", want.x, m_axis_tdata[95:64]);
					fails++;
				end
				if (m_axis_tdata[127:96] !== want.y) begin
					$error("snap_y: expected %h, got %h", want.y, m_axis_tdata[127:96]);
					fails++;
				end
				if (m_axis_tdata[159:128] !== want.z) begin
					$error("snap_z: expected %h, got %h", want.z, m_axis_tdata[159:128]);
					fails++;
				end
				if (m_axis_tdata[191:160] !== want.distance) begin
					$error("snap_distance: expected %h, got %h", want.distance,
						m_axis_tdata[191:160]);
					fails++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end
endmodule
